/* rtl/fed_pkg.sv */
package fed_pkg;

	localparam int DELAY_BITS     = 18;
	localparam int GAIN_BITS      = 16;
	localparam int CFG_DATA_BITS  = 18;
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ENABLE   = 2'd0,
		CFG_DELAY    = 2'd1,
		CFG_FEEDBACK = 2'd2,
		CFG_MIX      = 2'd3
	} cfg_index_t;

	localparam logic                  ENABLE_RST   = 1'b1;
	localparam logic [DELAY_BITS-1:0] DELAY_RST    = 18'd13440;
	localparam logic [GAIN_BITS-1:0]  FEEDBACK_RST = 16'd22938;
	localparam logic [GAIN_BITS-1:0]  MIX_RST      = 16'd22938;

endpackage

/* rtl/fed_in_if.sv */
interface fed_in_if #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          channel;

	modport source(output valid, sample_in, channel, input ready);
	modport sink(input valid, sample_in, channel, output ready);
endinterface

/* rtl/fed_out_if.sv */
interface fed_out_if #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          channel_out;

	modport source(output valid, sample_out, channel_out, input ready);
	modport sink(input valid, sample_out, channel_out, output ready);
endinterface

/* rtl/fed_cfg_if.sv */
interface fed_cfg_if import fed_pkg::*; ();
	logic                     valid;
	logic                     ready;
	cfg_index_t               index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/feedback_echo_delay.sv */
// Feedback echo over CHANNELS interleaved audio lines.
// in_ch takes one signed sample plus its channel per request; out_ch returns one
// sample per request, in order, with the channel copied. cfg writes enable,
// delay_length, feedback_gain and mix_gain by index; it is always ready. The
// user must write it only while the block is idle; the block does not enforce
// this. Writing enable = 0 rewinds every line. Throughput: one sample per cycle
// when no tap hazard or out_ch stall holds the input, set by the single read
// and single write of the delay RAM per sample. A sample whose tap hits a slot
// still being computed by one of the two samples ahead of it on the same line
// waits until that write lands, so a delay of one or two samples can stall it.
// Reset clears the write positions and fill marks; no clearing pass over the
// RAM is needed, since a slot not written since the last rewind reads as zero.
// When out_ch stalls, the output register holds its result and the pipeline
// keeps taking requests until its two inner stages are full.
module feedback_echo_delay import fed_pkg::*; #(
	parameter int LINE_DEPTH  = 262144,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input logic        clk,
	input logic        arst_n,
	fed_in_if.sink     in_ch,
	fed_out_if.source  out_ch,
	fed_cfg_if.sink    cfg
);

	localparam int AW        = $clog2(LINE_DEPTH);
	localparam int DW        = $clog2(LINE_DEPTH + 1);
	localparam int CW        = (DW > DELAY_BITS) ? DW : DELAY_BITS;
	localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_DEPTH = CHANNELS * (2 ** AW);
	localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SB        = SAMPLE_BITS;
	localparam int PW        = SB + GAIN_BITS + 1;
	localparam logic signed [PW-1:0] RND_HALF = PW'(32768);

	// configuration
	logic                  enable_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic [GAIN_BITS-1:0]  fb_q;
	logic [GAIN_BITS-1:0]  mix_q;

	// line state
	logic [AW-1:0] wp_q   [CHANNELS];
	logic          wrap_q [CHANNELS];

	// request stage
	logic [CHW-1:0] ch_idx;
	logic [AW-1:0]  wp_cur;
	logic [AW-1:0]  wp_nxt;
	logic           wrap_cur;
	logic [CW-1:0]  dl;
	logic [CW-1:0]  d_c;
	logic [CW:0]    rp_sum;
	logic [CW:0]    rp_full;
	logic [AW-1:0]  rp;
	logic           filled;
	logic [MAW-1:0] rd_addr;
	logic           hazard;
	logic           in_fire;

	// stage 1: RAM data out
	logic                 v_s1;
	logic                 en_s1;
	logic                 filled_s1;
	logic signed [SB-1:0] dry_s1;
	logic                 chan_s1;
	logic [MAW-1:0]       addr_s1;
	logic [SB-1:0]        ram_rd;
	logic signed [SB-1:0] delayed;
	logic signed [PW-1:0] pmix;
	logic signed [PW-1:0] pfb;

	// stage 2: round, add, saturate, write back
	logic                 v_s2;
	logic                 en_s2;
	logic signed [SB-1:0] dry_s2;
	logic                 chan_s2;
	logic [MAW-1:0]       addr_s2;
	logic signed [PW-1:0] pmix_s2;
	logic signed [PW-1:0] pfb_s2;
	logic signed [SB-1:0] mixed;
	logic signed [SB-1:0] back;

	// output register
	logic                 out_valid_q;
	logic signed [SB-1:0] out_sample_q;
	logic                 out_chan_q;

	logic adv_out;
	logic adv_s2;

	function automatic logic signed [SB-1:0] mix_sat(
		input logic signed [SB-1:0] dry,
		input logic signed [PW-1:0] prod
	);
		logic signed [PW-1:0] r;
		logic signed [SB:0]   sc;
		logic signed [SB+1:0] s;
		r  = prod + RND_HALF;
		sc = r[PW-1:16];
		s  = (SB+2)'(dry) + (SB+2)'(sc);
		if (s[SB+1:SB-1] == '0 || s[SB+1:SB-1] == '1) begin
			return s[SB-1:0];
		end
		return s[SB+1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			delay_q  <= DELAY_RST;
			fb_q     <= FEEDBACK_RST;
			mix_q    <= MIX_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ENABLE:   enable_q <= cfg.data[0];
				CFG_DELAY:    delay_q  <= cfg.data[DELAY_BITS-1:0];
				CFG_FEEDBACK: fb_q     <= cfg.data[GAIN_BITS-1:0];
				CFG_MIX:      mix_q    <= cfg.data[GAIN_BITS-1:0];
				default:      ;
			endcase
		end
	end

	// tap address for the incoming request
	always_comb begin
		if (int'(in_ch.channel) >= CHANNELS) begin
			ch_idx = CHW'(CHANNELS - 1);
		end else begin
			ch_idx = CHW'(in_ch.channel);
		end
		wp_cur   = wp_q[ch_idx];
		wrap_cur = wrap_q[ch_idx];
		wp_nxt   = (wp_cur == AW'(LINE_DEPTH - 1)) ? '0 : wp_cur + AW'(1);
		dl       = CW'(delay_q);
		if (dl == '0) begin
			d_c = CW'(1);
		end else if (dl > CW'(LINE_DEPTH)) begin
			d_c = CW'(LINE_DEPTH);
		end else begin
			d_c = dl;
		end
		rp_sum  = (CW+1)'(wp_cur) + (CW+1)'(LINE_DEPTH) - (CW+1)'(d_c);
		rp_full = (rp_sum >= (CW+1)'(LINE_DEPTH)) ? rp_sum - (CW+1)'(LINE_DEPTH) : rp_sum;
		rp      = rp_full[AW-1:0];
		// slots are written in order from zero after a rewind
		filled  = wrap_cur || (rp < wp_cur);
		rd_addr = MAW'({ch_idx, rp});
		// interlock: tap on a slot whose write is still in the pipe
		hazard  = enable_q &&
			((v_s1 && en_s1 && rd_addr == addr_s1) ||
			 (v_s2 && en_s2 && rd_addr == addr_s2));
	end

	assign adv_out     = v_s2 && (!out_valid_q || out_ch.ready);
	assign adv_s2      = v_s1 && (!v_s2 || adv_out);
	assign in_ch.ready = (!v_s1 || adv_s2) && !hazard;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]   <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else if (cfg.valid && cfg.index == CFG_ENABLE && !cfg.data[0]) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]   <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else if (in_fire && enable_q) begin
			wp_q[ch_idx] <= wp_nxt;
			if (wp_nxt == '0) begin
				wrap_q[ch_idx] <= 1'b1;
			end
		end
	end

	fed_ram #(
		.WIDTH(SB),
		.DEPTH(MEM_DEPTH)
	) u_line (
		.clk    (clk),
		.wr_en  (adv_out && en_s2),
		.wr_addr(addr_s2),
		.wr_data(back),
		.rd_en  (in_fire && enable_q),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= 1'b1;
			end else if (adv_out) begin
				v_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		delayed = (en_s1 && filled_s1) ? $signed(ram_rd) : '0;
		pmix    = delayed * $signed({1'b0, mix_q});
		pfb     = delayed * $signed({1'b0, fb_q});
		mixed   = mix_sat(dry_s2, pmix_s2);
		back    = mix_sat(dry_s2, pfb_s2);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			en_s1     <= enable_q;
			filled_s1 <= filled;
			dry_s1    <= in_ch.sample_in;
			chan_s1   <= in_ch.channel;
			addr_s1   <= MAW'({ch_idx, wp_cur});
		end
		if (adv_s2) begin
			en_s2   <= en_s1;
			dry_s2  <= dry_s1;
			chan_s2 <= chan_s1;
			addr_s2 <= addr_s1;
			pmix_s2 <= pmix;
			pfb_s2  <= pfb;
		end
		if (adv_out) begin
			out_sample_q <= en_s2 ? mixed : dry_s2;
			out_chan_q   <= chan_s2;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.sample_out  = out_sample_q;
	assign out_ch.channel_out = out_chan_q;

endmodule

/* rtl/fed_ram.sv */
module fed_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AB-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AB-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fed_pkg::*;

	localparam int LINE_DEPTH   = 262144;
	localparam int CHANNELS     = 2;
	localparam int SAMPLE_BITS  = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASE_ITEMS  = 120;
	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   channel;
	} audio_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fed_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_bus();
	fed_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_bus();
	fed_cfg_if cfg_bus();

	feedback_echo_delay #(
		.LINE_DEPTH(LINE_DEPTH),
		.CHANNELS(CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.cfg(cfg_bus)
	);

	always #5 clk = ~clk;

	audio_req_t sample_q[$];
	audio_req_t echo_q[$];

	// echo model state
	int                    line_mem [int];
	int unsigned           wr_pos [CHANNELS];
	logic                  echo_en;
	logic [DELAY_BITS-1:0] echo_delay;
	logic [GAIN_BITS-1:0]  fb_gain;
	logic [GAIN_BITS-1:0]  mix_gain;

	logic in_fire        = 1'b0;
	int   src_idle_pct   = 0;
	int   sink_stall_pct = 0;
	int   hold_asked     = 0;
	int   hold_served    = 0;
	int   hold_left      = 0;
	int   pushed         = 0;
	int   accepted       = 0;
	int   checked        = 0;
	int   errors         = 0;
	int   settings       = 0;
	int   cycle_count    = 0;

	function automatic longint clamp_sample(longint v);
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			return SAMPLE_MIN;
		return v;
	endfunction

	// Q0.16 gain, rounded half up (arithmetic shift floors)
	function automatic longint gain_q16(longint x, logic [GAIN_BITS-1:0] g);
		longint p;
		p = x * longint'(g) + 64'sd32768;
		return p >>> 16;
	endfunction

	function automatic audio_req_t echo_step(audio_req_t req);
		audio_req_t  res;
		longint      dry;
		longint      delayed;
		longint      back;
		int unsigned tap;
		int unsigned wp;
		int unsigned rp;
		int          line_base;
		dry = longint'($signed(req.sample));
		res = req;
		if (echo_en) begin
			tap = echo_delay;
			if (tap < 1)
				tap = 1;
			if (tap > LINE_DEPTH)
				tap = LINE_DEPTH;
			wp = wr_pos[req.channel];
			rp = (wp + LINE_DEPTH - tap) % LINE_DEPTH;
			line_base = req.channel * LINE_DEPTH;
			delayed = line_mem.exists(line_base + rp) ? line_mem[line_base + rp] : 0;
			res.sample = SAMPLE_BITS'(clamp_sample(dry + gain_q16(delayed, mix_gain)));
			back = clamp_sample(dry + gain_q16(delayed, fb_gain));
			line_mem[line_base + wp] = int'(back);
			wr_pos[req.channel] = (wp + 1) % LINE_DEPTH;
		end
		return res;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(9))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2, 3: return SAMPLE_BITS'($urandom_range(4095)) - SAMPLE_BITS'(2048);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s", $time, msg);
	endfunction

	// sample source
	always @(negedge clk) begin : drive_samples
		audio_req_t nxt;
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
		end else if (!in_bus.valid || in_fire) begin
			if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = sample_q.pop_front();
				in_bus.valid     <= 1'b1;
				in_bus.sample_in <= nxt.sample;
				in_bus.channel   <= nxt.channel;
			end else begin
				in_bus.valid <= 1'b0;
			end
		end
	end

	// result sink, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served   <= hold_asked;
			hold_left     <= HOLD_CYCLES;
			out_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			out_bus.ready <= 1'b0;
		end else begin
			out_bus.ready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : watch
		audio_req_t taken;
		audio_req_t want;
		audio_req_t pred;
		in_fire <= arst_n && in_bus.valid && in_bus.ready;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					CFG_ENABLE: begin
						echo_en = cfg_bus.data[0];
						if (!echo_en) begin
							line_mem.delete();
							foreach (wr_pos[c])
								wr_pos[c] = 0;
						end
					end
					CFG_DELAY:    echo_delay = cfg_bus.data[DELAY_BITS-1:0];
					CFG_FEEDBACK: fb_gain = cfg_bus.data[GAIN_BITS-1:0];
					CFG_MIX:      mix_gain = cfg_bus.data[GAIN_BITS-1:0];
					default: ;
				endcase
			end
			if (in_bus.valid && in_bus.ready) begin
				taken.sample  = in_bus.sample_in;
				taken.channel = in_bus.channel;
				pred = echo_step(taken);
				echo_q = {echo_q, pred};
				accepted++;
			end
			if (out_bus.valid && out_bus.ready) begin
				checked++;
				if (echo_q.size() == 0) begin
					note_error($sformatf("unexpected result %0d on channel %0d",
						$signed(out_bus.sample_out), out_bus.channel_out));
				end else begin
					want = echo_q.pop_front();
					if (out_bus.sample_out !== want.sample || out_bus.channel_out !== want.channel)
						note_error($sformatf("mismatch: expected %0d ch %0d, got %0d ch %0d",
							$signed(want.sample), want.channel,
							$signed(out_bus.sample_out), out_bus.channel_out));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				echo_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_sample(logic [SAMPLE_BITS-1:0] s, logic c);
		audio_req_t r;
		r.sample  = s;
		r.channel = c;
		sample_q = {sample_q, r};
		pushed++;
	endtask

	task automatic set_reg(cfg_index_t idx, int unsigned value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= CFG_DATA_BITS'(value);
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (!(accepted == pushed && echo_q.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(logic en, logic wipe, int unsigned dly, int unsigned fb,
			int unsigned mix);
		if (wipe || !en)
			set_reg(CFG_ENABLE, 0);
		if (en)
			set_reg(CFG_ENABLE, 1);
		set_reg(CFG_DELAY, dly);
		set_reg(CFG_FEEDBACK, fb);
		set_reg(CFG_MIX, mix);
		settings++;
	endtask

	initial begin
		logic        en;
		logic        wipe;
		int unsigned dly;
		int unsigned fb;
		int unsigned mix;

		in_bus.valid     = 1'b0;
		in_bus.sample_in = '0;
		in_bus.channel   = 1'b0;
		out_bus.ready    = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.index    = CFG_ENABLE;
		cfg_bus.data     = '0;
		echo_en    = ENABLE_RST;
		echo_delay = DELAY_RST;
		fb_gain    = FEEDBACK_RST;
		mix_gain   = MIX_RST;
		foreach (wr_pos[c])
			wr_pos[c] = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: long delay, taps still read zero
		push_sample(24'h7FFFFF, 1'b0);
		push_sample(24'h800000, 1'b1);
		push_sample(24'h000000, 1'b0);
		push_sample(24'hFFFFFF, 1'b1);
		wait_idle();

		// zero delay acts as one, feedback at the top of its range, half-step rounding
		apply_setting(1'b1, 1'b1, 0, 65535, 32768);
		push_sample(24'h000001, 1'b0);
		push_sample(24'h000000, 1'b0);
		push_sample(24'hFFFFFF, 1'b0);
		push_sample(24'hFFFFFF, 1'b0);
		push_sample(24'h000000, 1'b0);
		repeat (3)
			push_sample(24'h7FFFFF, 1'b1);
		repeat (3)
			push_sample(24'h800000, 1'b0);
		push_sample(24'h000100, 1'b1);
		push_sample(24'hFFFF00, 1'b0);
		wait_idle();

		// bypass
		apply_setting(1'b0, 1'b1, 5, 58982, 65535);
		push_sample(24'h7FFFFF, 1'b0);
		push_sample(24'h800000, 1'b1);
		push_sample(24'h123456, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
				default: begin src_idle_pct = 10; sink_stall_pct = 10; end
			endcase
			en   = 1'b1;
			wipe = $urandom_range(1);
			fb   = $urandom_range(65535);
			mix  = $urandom_range(65535);
			dly  = $urandom_range(1, 40);
			case (ph)
				0: begin dly = 1; fb = 58982; mix = 65535; wipe = 1'b1; end
				1: begin dly = 2; fb = 0; mix = 0; end
				2: begin dly = 3; fb = 65535; mix = 22938; end
				3: dly = 262143;	// longest delay the register holds
				4: dly = 192000;
				5: en = 1'b0;
				6: dly = $urandom_range(1, 300);
				default: ;
			endcase
			apply_setting(en, wipe, dly, fb, mix);
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_sample(rand_sample(), 1'($urandom_range(1)));
			wait_idle();
		end

		// long output hold-off with a busy source, short delay for tap hazards
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		apply_setting(1'b1, 1'b0, 1, 45000, 40000);
		hold_asked++;
		for (int i = 0; i < 100; i++)
			push_sample(rand_sample(), 1'($urandom_range(1)));
		wait_idle();

		$display("Echo run: %0d samples over %0d register settings, %0d results checked",
			accepted, settings, checked);
		$display("Covered bypass, clears, delays 0 to 262143, full gain range, %0d mismatches",
			errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
